// ----- hw/rtl/bpr_pkg.sv -----
// Shared types, constants and helpers for the BMP pixel to RGB555 decoder.
// Used by the interfaces, the front, the queue, the back and the top level.
`default_nettype none

package bpr_pkg;

  // image and palette limits
  localparam int MAX_DIM     = 1024;
  localparam int PAL_DEPTH   = 256;
  localparam int COLOR_W     = 16;
  localparam int COORD_W     = 10;
  localparam int DIM_W       = 11;
  localparam int IDX_W       = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // item function codes
  localparam logic FUNC_PAL_WR = 1'b0;
  localparam logic FUNC_DATA   = 1'b1;

  // pixel mode codes
  typedef enum logic [2:0] {
    MODE_PAL4  = 3'd0,
    MODE_PAL8  = 3'd1,
    MODE_RGB16 = 3'd2,
    MODE_RGB24 = 3'd3,
    MODE_RGB32 = 3'd4
  } mode_t;

  // one pixel on its way to the back
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               done;
    logic               last;
    logic               use_pal;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
  } pix_t;

  // one queue entry: a palette write (idx and color of p0) or one or two pixels
  typedef struct packed {
    logic is_wr;
    logic two;
    pix_t p0;
    pix_t p1;
  } entry_t;

  // pack three five-bit channels, opaque bit set
  function automatic logic [COLOR_W-1:0] rgb555(input logic [4:0] r5,
                                                input logic [4:0] g5,
                                                input logic [4:0] b5);
    rgb555 = {1'b1, b5, g5, r5};
  endfunction

  // clamp a dimension register to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      clamp_dim = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      clamp_dim = DIM_W'(MAX_DIM);
    end else begin
      clamp_dim = v;
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bpr_if.sv -----
// Handshake channel interfaces: input items, result items and register writes.
// Depends on bpr_pkg for field widths.
`default_nettype none

interface bpr_in_if;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [bpr_pkg::IDX_W-1:0] pal_index;
  logic [7:0]               pal_blue;
  logic [7:0]               pal_green;
  logic [7:0]               pal_red;
  logic [7:0]               data_byte;

  modport source (output valid, func, pal_index, pal_blue, pal_green, pal_red, data_byte,
                  input ready);
  modport sink (input valid, func, pal_index, pal_blue, pal_green, pal_red, data_byte,
                output ready);
endinterface

interface bpr_out_if;
  logic                         valid;
  logic                         ready;
  logic [bpr_pkg::COORD_W-1:0]  pixel_x;
  logic [bpr_pkg::COORD_W-1:0]  pixel_y;
  logic [bpr_pkg::COLOR_W-1:0]  color;
  logic                         last_of_item;
  logic                         image_done;

  modport source (output valid, pixel_x, pixel_y, color, last_of_item, image_done,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, color, last_of_item, image_done,
                output ready);
endinterface

interface bpr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 index;
  logic [bpr_pkg::DIM_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bpr_fifo.sv -----
// Short queue of decoded entries between the front and the back.
// Depends on bpr_pkg for the entry type and depth.
`default_nettype none

module bpr_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bpr_pkg::entry_t push_data,
  output      logic            full,
  output      logic            head_valid,
  output      bpr_pkg::entry_t head,
  input  wire logic            pop,
  output      logic [bpr_pkg::QPTR_W:0] count
);

  bpr_pkg::entry_t                mem_r [bpr_pkg::QUEUE_DEPTH];
  logic [bpr_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [bpr_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [bpr_pkg::QPTR_W:0]       count_r, count_nxt;
  logic                           do_push, do_pop;

  assign full       = (count_r == (bpr_pkg::QPTR_W+1)'(bpr_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign count      = count_r;
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (bpr_pkg::QPTR_W)'(do_push);
    rd_ptr_nxt = rd_ptr_r + (bpr_pkg::QPTR_W)'(do_pop);
    count_nxt  = count_r + (bpr_pkg::QPTR_W+1)'(do_push) - (bpr_pkg::QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bpr_front.sv -----
// Front part: takes items and register writes, tracks the stream position
// and turns palette writes and completed pixels into queue entries. Depends on bpr_pkg and bpr_if.
`default_nettype none

module bpr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  bpr_in_if.sink               in_bus,
  bpr_cfg_if.sink              cfg_bus,
  input  wire logic            q_full,
  output      logic            push,
  output      bpr_pkg::entry_t push_data
);

  localparam int DW = bpr_pkg::DIM_W;
  localparam int CW = bpr_pkg::COORD_W;

  logic [2:0]    mode_r;
  logic [DW-1:0] width_r;
  logic [DW-1:0] height_r;
  logic [DW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [1:0]    rbc_r, rbc_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [15:0]   partial_r, partial_nxt;
  logic          pad_r, pad_nxt;

  logic [DW-1:0] w, h;
  logic [DW-1:0] row_ext, row_inc;
  logic [DW-1:0] col1, col_end;
  logic [DW-1:0] y_full;
  logic          row_last;
  logic          do_check;
  logic          in_acc;
  logic [7:0]    b;
  bpr_pkg::pix_t px0, px1;

  assign in_bus.ready  = !q_full;
  assign cfg_bus.ready = 1'b1;
  assign in_acc        = in_bus.valid && !q_full;
  assign b             = in_bus.data_byte;

  // clamped geometry and per-position fields
  always_comb begin
    w        = bpr_pkg::clamp_dim(width_r);
    h        = bpr_pkg::clamp_dim(height_r);
    row_ext  = {1'b0, row_r};
    row_inc  = row_ext + DW'(1);
    row_last = (row_inc == h);
    y_full   = h - DW'(1) - row_ext;
    col1     = col_r + DW'(1);
  end

  // decode one item
  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    rbc_nxt     = rbc_r;
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    pad_nxt     = pad_r;
    col_end     = col_r;
    do_check    = 1'b0;
    push        = 1'b0;

    px0         = '0;
    px0.x       = col_r[CW-1:0];
    px0.y       = y_full[CW-1:0];
    px0.done    = (col1 == w) && row_last;
    px0.last    = 1'b1;
    px1         = '0;
    px1.x       = col1[CW-1:0];
    px1.y       = y_full[CW-1:0];
    px1.done    = ((col1 + DW'(1)) == w) && row_last;
    px1.last    = 1'b1;
    push_data   = '0;

    if (in_bus.func == bpr_pkg::FUNC_PAL_WR) begin
      // palette write travels through the queue to keep order with lookups
      push               = 1'b1;
      push_data.is_wr    = 1'b1;
      push_data.p0.idx   = in_bus.pal_index;
      push_data.p0.color = bpr_pkg::rgb555(in_bus.pal_red[7:3], in_bus.pal_green[7:3],
                                           in_bus.pal_blue[7:3]);
    end else if (mode_r <= 3'(bpr_pkg::MODE_RGB32)) begin
      rbc_nxt = rbc_r + 2'd1;
      if (pad_r) begin
        // row padding bytes
        if (rbc_nxt == 2'd0) begin
          pad_nxt = 1'b0;
        end
      end else begin
        case (mode_r)
          3'(bpr_pkg::MODE_PAL4): begin
            push          = 1'b1;
            px0.use_pal   = 1'b1;
            px0.idx       = {4'd0, b[7:4]};
            px1.use_pal   = 1'b1;
            px1.idx       = {4'd0, b[3:0]};
            if (col1 < w) begin
              px0.last      = 1'b0;
              push_data.two = 1'b1;
              col_end       = col1 + DW'(1);
            end else begin
              col_end       = col1;
            end
            do_check = 1'b1;
          end
          3'(bpr_pkg::MODE_PAL8): begin
            push        = 1'b1;
            px0.use_pal = 1'b1;
            px0.idx     = b;
            col_end     = col1;
            do_check    = 1'b1;
          end
          3'(bpr_pkg::MODE_RGB16): begin
            if (phase_r == 2'd0) begin
              partial_nxt = {8'd0, b};
              phase_nxt   = 2'd1;
            end else begin
              phase_nxt = 2'd0;
              push      = 1'b1;
              px0.color = bpr_pkg::rgb555(b[6:2], {b[1:0], partial_r[7:5]}, partial_r[4:0]);
              col_end   = col1;
              do_check  = 1'b1;
            end
          end
          default: begin
            // 24 and 32 bit modes: blue, green, red, then alpha in 32 bit
            case (phase_r)
              2'd0: begin
                partial_nxt = {8'd0, b};
                phase_nxt   = 2'd1;
              end
              2'd1: begin
                partial_nxt = {b, partial_r[7:0]};
                phase_nxt   = 2'd2;
              end
              2'd2: begin
                push      = 1'b1;
                px0.color = bpr_pkg::rgb555(b[7:3], partial_r[15:11], partial_r[7:3]);
                col_end   = col1;
                col_nxt   = col1;
                if (mode_r == 3'(bpr_pkg::MODE_RGB32)) begin
                  phase_nxt = 2'd3;
                end else begin
                  phase_nxt = 2'd0;
                  do_check  = 1'b1;
                end
              end
              default: begin
                phase_nxt = 2'd0;
                do_check  = 1'b1;
              end
            endcase
          end
        endcase

        // end of row check
        if (do_check) begin
          col_nxt = col_end;
          if (col_end >= w) begin
            col_nxt = '0;
            row_nxt = row_last ? '0 : row_inc[CW-1:0];
            if (rbc_nxt != 2'd0) begin
              pad_nxt = 1'b1;
            end
          end
        end
      end
    end

    if (!push_data.is_wr) begin
      push_data.p0 = px0;
      push_data.p1 = px1;
    end
    push = push && in_acc;
  end

  // configuration and stream position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 3'(bpr_pkg::MODE_RGB24);
      width_r   <= DW'(1);
      height_r  <= DW'(1);
      col_r     <= '0;
      row_r     <= '0;
      rbc_r     <= '0;
      phase_r   <= '0;
      partial_r <= '0;
      pad_r     <= 1'b0;
    end else if (cfg_bus.valid && cfg_bus.index <= bpr_pkg::REG_HEIGHT) begin
      unique case (cfg_bus.index)
        bpr_pkg::REG_MODE:  mode_r   <= cfg_bus.data[2:0];
        bpr_pkg::REG_WIDTH: width_r  <= cfg_bus.data;
        default:            height_r <= cfg_bus.data;
      endcase
      col_r     <= '0;
      row_r     <= '0;
      rbc_r     <= '0;
      phase_r   <= '0;
      partial_r <= '0;
      pad_r     <= 1'b0;
    end else if (in_acc) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      rbc_r     <= rbc_nxt;
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
      pad_r     <= pad_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bpr_back.sv -----
// Back part: drains queue entries, writes or reads the palette RAM and
// drives the result register. Depends on bpr_pkg, bpr_if and bpr_ram.
`default_nettype none

module bpr_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire bpr_pkg::entry_t head,
  output      logic            pop,
  bpr_out_if.source            out_bus
);

  logic          b_valid_r, b_valid_nxt;
  bpr_pkg::pix_t b_pix_r, b_pix_nxt;
  logic          sel_r, sel_nxt;
  logic          adv;
  logic          we, re;
  bpr_pkg::pix_t cur;
  logic [bpr_pkg::COLOR_W-1:0] rdata;

  bpr_ram #(
    .WIDTH (bpr_pkg::COLOR_W),
    .DEPTH (bpr_pkg::PAL_DEPTH)
  ) u_pal (
    .clk   (clk),
    .we    (we),
    .waddr (head.p0.idx),
    .wdata (head.p0.color),
    .re    (re),
    .raddr (cur.idx),
    .rdata (rdata)
  );

  assign cur = sel_r ? head.p1 : head.p0;
  assign adv = !b_valid_r || out_bus.ready;

  // issue one palette write or one pixel per cycle, pixels only while the result register can advance
  always_comb begin
    pop         = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    b_valid_nxt = b_valid_r;
    b_pix_nxt   = b_pix_r;
    sel_nxt     = sel_r;
    if (head_valid && head.is_wr) begin
      we  = 1'b1;
      pop = 1'b1;
      if (adv) begin
        b_valid_nxt = 1'b0;
      end
    end else if (adv) begin
      b_valid_nxt = head_valid;
      if (head_valid) begin
        b_pix_nxt = cur;
        re        = cur.use_pal;
        if (head.two && !sel_r) begin
          sel_nxt = 1'b1;
        end else begin
          sel_nxt = 1'b0;
          pop     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      sel_r     <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      sel_r     <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_pix_r <= b_pix_nxt;
  end

  // result register outputs
  assign out_bus.valid        = b_valid_r;
  assign out_bus.pixel_x      = b_pix_r.x;
  assign out_bus.pixel_y      = b_pix_r.y;
  assign out_bus.color        = b_pix_r.use_pal ? rdata : b_pix_r.color;
  assign out_bus.last_of_item = b_pix_r.last;
  assign out_bus.image_done   = b_pix_r.done;

endmodule

`default_nettype wire

// ----- hw/rtl/bmp_pixel_to_rgb555_top.sv -----
// BMP pixel-array decoder to RGB555, top level: front, queue and back.
// With the queue empty, an accepted item is registered in the queue and then in the result register.
// Items are taken at one per cycle while the queue is not full; results leave at one per
// cycle while the receiver is ready, so a 4 bpp byte with two pixels holds the palette read port for both.
// Reset (rst_n low, synchronous) clears position, queue and result valid and
// sets mode 24 bpp, width 1, height 1; the palette holds garbage until written.
`default_nettype none

module bmp_pixel_to_rgb555_top (
  input  wire logic clk,
  input  wire logic rst_n,
  bpr_in_if.sink    in_bus,
  bpr_out_if.source out_bus,
  bpr_cfg_if.sink   cfg_bus
);

  logic                      push;
  bpr_pkg::entry_t           push_data;
  logic                      q_full;
  logic                      head_valid;
  bpr_pkg::entry_t           head;
  logic                      pop;
  logic [bpr_pkg::QPTR_W:0]  q_count;

  bpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .cfg_bus   (cfg_bus),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  bpr_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .count      (q_count)
  );

  bpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_bus    (out_bus)
  );

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= (bpr_pkg::QPTR_W+1)'(bpr_pkg::QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  // the final pixel of the image is always the last pixel of its item
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.image_done |-> out_bus.last_of_item)
    else $error("image done without last of item");

  // a palette write at the queue head is retired in the same cycle
  a_wr_drain: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid && head.is_wr |-> pop)
    else $error("palette write stuck at queue head");

  // a push into the queue means the front accepted an item
  a_push_acc: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> in_bus.valid && in_bus.ready)
    else $error("queue push without accepted item");

endmodule

`default_nettype wire

// ----- tb/bmp_pixel_to_rgb555_top_tb.sv -----
// Self-checking testbench for bmp_pixel_to_rgb555_top: streams pixel-array bytes
// and palette writes, decodes them in a local model and checks every output pixel.
// Depends on bpr_pkg and the channel interfaces bpr_in_if, bpr_out_if, bpr_cfg_if.

module bmp_pixel_to_rgb555_top_tb;
  import bpr_pkg::*;

  localparam int HOLD_LONG      = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEM_BUDGET    = 1550;
  localparam int QUIET_TAIL     = 300;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PRINT_LIMIT    = 100;

  // index past the register list: accepted, changes nothing
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic       func;
    logic [7:0] pal_index;
    logic [7:0] pal_blue;
    logic [7:0] pal_green;
    logic [7:0] pal_red;
    logic [7:0] data_byte;
  } byte_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic               done;
  } pixel_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bpr_in_if  in_ch ();
  bpr_out_if out_ch ();
  bpr_cfg_if cfg_ch ();

  bmp_pixel_to_rgb555_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  always #5 clk = ~clk;

  // decoder model state
  logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
  logic [2:0]         cur_mode;
  logic [DIM_W-1:0]   cur_width;
  logic [DIM_W-1:0]   cur_height;
  int unsigned        col_cnt;
  int unsigned        row_cnt;
  logic [1:0]         row_bytes;
  logic [1:0]         byte_phase;
  logic [15:0]        partial;
  logic               pad_skip;
  pixel_t             stage_pix [2];
  int                 stage_n;
  pixel_t             pixel_expect_q [$];

  // stimulus and bookkeeping
  byte_item_t pending_q [$];
  byte_item_t in_cur;
  int         items_pushed    = 0;
  int         items_taken     = 0;
  int         err_count       = 0;
  int         in_gap          = 0;
  int         out_gap         = 0;
  int         quiet_cycles    = 0;
  int         long_hold_cnt   = 0;
  bit         long_hold_taken = 1'b0;
  bit         want_long_hold  = 1'b0;
  bit         idle_on         = 1'b1;

  function automatic int unsigned dim_eff(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_W'(MAX_DIM)) return MAX_DIM;
    return v;
  endfunction

  function automatic logic [COLOR_W-1:0] pack555(input logic [4:0] r, input logic [4:0] g,
                                                 input logic [4:0] b);
    return {1'b1, b, g, r};
  endfunction

  task automatic restart_position();
    col_cnt    = 0;
    row_cnt    = 0;
    row_bytes  = '0;
    byte_phase = '0;
    partial    = '0;
    pad_skip   = 1'b0;
  endtask

  // register write as seen by the model
  task automatic apply_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    case (idx)
      REG_MODE:   cur_mode = val[2:0];
      REG_WIDTH:  cur_width = val;
      REG_HEIGHT: cur_height = val;
      default:    return;
    endcase
    restart_position();
  endtask

  // stage one pixel at the current position and advance the column
  task automatic push_pixel(input logic [COLOR_W-1:0] color);
    int unsigned w;
    int unsigned h;
    pixel_t      p;
    w       = dim_eff(cur_width);
    h       = dim_eff(cur_height);
    p.x     = col_cnt[COORD_W-1:0];
    p.y     = COORD_W'(h - 1 - row_cnt);
    p.color = color;
    p.last  = 1'b0;
    p.done  = (col_cnt + 1 == w) && (row_cnt + 1 == h);
    stage_pix[stage_n] = p;
    stage_n++;
    col_cnt++;
  endtask

  // wrap column and row, arm padding skip if the row is not word aligned
  task automatic close_row();
    if (col_cnt < dim_eff(cur_width)) return;
    col_cnt = 0;
    row_cnt++;
    if (row_cnt >= dim_eff(cur_height)) row_cnt = 0;
    if (row_bytes != 2'd0) pad_skip = 1'b1;
  endtask

  // model one accepted item and queue the pixels it produces
  task automatic decode_item(input byte_item_t it);
    logic [7:0]  b;
    logic [15:0] v;
    b       = it.data_byte;
    stage_n = 0;
    if (it.func == FUNC_PAL_WR) begin
      pal_mem[it.pal_index] = pack555(it.pal_red[7:3], it.pal_green[7:3], it.pal_blue[7:3]);
      return;
    end
    if (cur_mode > MODE_RGB32) return;
    row_bytes = row_bytes + 2'd1;
    if (pad_skip) begin
      if (row_bytes == 2'd0) pad_skip = 1'b0;
      return;
    end
    case (cur_mode)
      MODE_PAL4: begin
        push_pixel(pal_mem[{4'd0, b[7:4]}]);
        if (col_cnt < dim_eff(cur_width)) push_pixel(pal_mem[{4'd0, b[3:0]}]);
        close_row();
      end
      MODE_PAL8: begin
        push_pixel(pal_mem[b]);
        close_row();
      end
      MODE_RGB16: begin
        if (byte_phase == 2'd0) begin
          partial    = {8'd0, b};
          byte_phase = 2'd1;
        end else begin
          v          = {b, partial[7:0]};
          byte_phase = 2'd0;
          push_pixel(pack555(v[14:10], v[9:5], v[4:0]));
          close_row();
        end
      end
      default: begin
        case (byte_phase)
          2'd0: begin
            partial    = {8'd0, b};
            byte_phase = 2'd1;
          end
          2'd1: begin
            partial    = {b, partial[7:0]};
            byte_phase = 2'd2;
          end
          2'd2: begin
            push_pixel(pack555(b[7:3], partial[15:11], partial[7:3]));
            if (cur_mode == MODE_RGB32) begin
              byte_phase = 2'd3;
            end else begin
              byte_phase = 2'd0;
              close_row();
            end
          end
          default: begin
            // alpha byte
            byte_phase = 2'd0;
            close_row();
          end
        endcase
      end
    endcase
    if (stage_n > 0) stage_pix[stage_n-1].last = 1'b1;
    for (int i = 0; i < stage_n; i++) pixel_expect_q.push_back(stage_pix[i]);
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_LIMIT) $display("mismatch: %s", msg);
  endtask

  // compare one output pixel against the oldest expected one
  task automatic check_pixel();
    pixel_t want;
    if (pixel_expect_q.size() == 0) begin
      report_mismatch($sformatf("pixel x=%0d y=%0d with nothing expected",
                                out_ch.pixel_x, out_ch.pixel_y));
      return;
    end
    want = pixel_expect_q.pop_front();
    if (out_ch.pixel_x !== want.x)
      report_mismatch($sformatf("pixel_x exp %0d got %0d", want.x, out_ch.pixel_x));
    if (out_ch.pixel_y !== want.y)
      report_mismatch($sformatf("pixel_y exp %0d got %0d (x=%0d)", want.y, out_ch.pixel_y,
                                want.x));
    if (out_ch.color !== want.color)
      report_mismatch($sformatf("color exp %h got %h (x=%0d y=%0d)", want.color,
                                out_ch.color, want.x, want.y));
    if (out_ch.last_of_item !== want.last)
      report_mismatch($sformatf("last_of_item exp %b got %b (x=%0d y=%0d)", want.last,
                                out_ch.last_of_item, want.x, want.y));
    if (out_ch.image_done !== want.done)
      report_mismatch($sformatf("image_done exp %b got %b (x=%0d y=%0d)", want.done,
                                out_ch.image_done, want.x, want.y));
  endtask

  // input driver: takes items from the pending queue, random gap bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_item(in_cur);
        items_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (idle_on && long_hold_cnt == 0 && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 2);
          in_ch.valid <= 1'b0;
        end else begin
          in_cur = pending_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.func      <= in_cur.func;
          in_ch.pal_index <= in_cur.pal_index;
          in_ch.pal_blue  <= in_cur.pal_blue;
          in_ch.pal_green <= in_cur.pal_green;
          in_ch.pal_red   <= in_cur.pal_red;
          in_ch.data_byte <= in_cur.data_byte;
        end
      end
    end
  end

  // output monitor: checks accepted pixels, random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_pixel();
      if (long_hold_cnt > 0) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one long receiver stall so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      long_hold_cnt   <= 0;
      long_hold_taken <= 1'b0;
    end else if (want_long_hold && !long_hold_taken) begin
      long_hold_cnt   <= HOLD_LONG;
      long_hold_taken <= 1'b1;
    end else if (long_hold_cnt > 0) begin
      long_hold_cnt <= long_hold_cnt - 1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bmp_pixel_to_rgb555_top_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_data(input logic [7:0] b);
    byte_item_t it;
    it.func      = FUNC_DATA;
    it.pal_index = 8'($urandom);
    it.pal_blue  = 8'($urandom);
    it.pal_green = 8'($urandom);
    it.pal_red   = 8'($urandom);
    it.data_byte = b;
    pending_q.push_back(it);
    items_pushed++;
  endtask

  task automatic queue_pal(input logic [7:0] idx, input logic [7:0] bl, input logic [7:0] gr,
                           input logic [7:0] rd);
    byte_item_t it;
    it.func      = FUNC_PAL_WR;
    it.pal_index = idx;
    it.pal_blue  = bl;
    it.pal_green = gr;
    it.pal_red   = rd;
    it.data_byte = 8'($urandom);
    pending_q.push_back(it);
    items_pushed++;
  endtask

  // wait until every item is in and every pixel out, then let the pipe empty
  task automatic settle();
    while (!(items_taken == items_pushed && pixel_expect_q.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic write_dims(input logic [2:0] mode, input logic [DIM_W-1:0] wid,
                            input logic [DIM_W-1:0] hgt);
    write_reg(REG_MODE, {8'($urandom), mode});
    write_reg(REG_WIDTH, wid);
    write_reg(REG_HEIGHT, hgt);
  endtask

  // sequencer: directed cases, then random image phases
  initial begin
    int               n;
    int               bpr;
    int               img;
    int               phase_no;
    logic [2:0]       mode;
    logic [DIM_W-1:0] wid;
    logic [DIM_W-1:0] hgt;

    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_DATA;
    in_ch.pal_index  = '0;
    in_ch.pal_blue   = '0;
    in_ch.pal_green  = '0;
    in_ch.pal_red    = '0;
    in_ch.data_byte  = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_MODE;
    cfg_ch.data      = '0;
    cur_mode         = MODE_RGB24;
    cur_width        = DIM_W'(1);
    cur_height       = DIM_W'(1);
    restart_position();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: split a 24 bpp pixel around a write past the register list
    queue_data(8'h00);
    queue_data(8'hFF);
    settle();
    write_reg(REG_SPARE, 11'h7FF);
    queue_data(8'h80);
    queue_data(8'hA5);
    settle();

    // full palette load, extreme colors at both ends
    for (int i = 0; i < PAL_DEPTH; i++) begin
      if (i == 0) queue_pal(8'h00, 8'h00, 8'h00, 8'h00);
      else if (i == PAL_DEPTH - 1) queue_pal(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      else queue_pal(8'(i), 8'($urandom), 8'($urandom), 8'($urandom));
    end
    settle();

    // 4 bpp with odd width: low nibble of the last byte dropped, row padding
    write_dims(MODE_PAL4, DIM_W'(3), DIM_W'(2));
    queue_data(8'h0F);
    queue_data(8'hF0);
    queue_data(8'h12);
    queue_data(8'h34);
    queue_data(8'hF0);
    queue_data(8'h0F);
    queue_data(8'h56);
    queue_data(8'h78);
    settle();

    // 8 bpp with zero width and oversized height, both clamped
    write_dims(MODE_PAL8, DIM_W'(0), DIM_W'(2047));
    queue_data(8'h00);
    queue_data(8'hFF);
    queue_data(8'h7F);
    settle();

    // 16 bpp, one row without padding
    write_dims(MODE_RGB16, DIM_W'(2), DIM_W'(1));
    queue_data(8'h00);
    queue_data(8'h00);
    queue_data(8'hFF);
    queue_data(8'hFF);
    settle();

    // 32 bpp with alpha skipped, widest row
    write_dims(MODE_RGB32, DIM_W'(1024), DIM_W'(1));
    queue_data(8'hFF);
    queue_data(8'h00);
    queue_data(8'hFF);
    queue_data(8'h00);
    settle();

    // unused modes swallow bytes
    write_reg(REG_MODE, DIM_W'(5));
    queue_data(8'h11);
    queue_data(8'h22);
    settle();
    write_reg(REG_MODE, DIM_W'(7));
    queue_data(8'h33);
    settle();

    // random phases, mostly small complete images
    phase_no = 0;
    while (items_pushed < ITEM_BUDGET) begin
      if (items_pushed > ITEM_BUDGET - QUIET_TAIL) idle_on = 1'b0;

      if ($urandom_range(0, 19) == 0) mode = 3'($urandom_range(5, 7));
      else mode = 3'($urandom_range(0, 4));
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       wid = DIM_W'(0);
          1:       wid = DIM_W'(1023);
          2:       wid = DIM_W'(1024);
          default: wid = DIM_W'(2047);
        endcase
      end else begin
        wid = DIM_W'($urandom_range(1, 12));
      end
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       hgt = DIM_W'(0);
          1:       hgt = DIM_W'(1024);
          default: hgt = DIM_W'(2047);
        endcase
      end else begin
        hgt = DIM_W'($urandom_range(1, 4));
      end
      if (phase_no == 3) mode = MODE_PAL4;

      if (phase_no == 3 || $urandom_range(0, 3) != 0) write_reg(REG_MODE, {8'($urandom), mode});
      if ($urandom_range(0, 3) != 0) write_reg(REG_WIDTH, wid);
      if ($urandom_range(0, 3) != 0) write_reg(REG_HEIGHT, hgt);
      if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, DIM_W'($urandom));

      case (cur_mode)
        MODE_PAL4:  bpr = (dim_eff(cur_width) + 1) / 2;
        MODE_PAL8:  bpr = dim_eff(cur_width);
        MODE_RGB16: bpr = 2 * dim_eff(cur_width);
        MODE_RGB24: bpr = 3 * dim_eff(cur_width);
        default:    bpr = 4 * dim_eff(cur_width);
      endcase
      img = ((bpr + 3) / 4) * 4 * dim_eff(cur_height);
      if (cur_mode > MODE_RGB32) n = $urandom_range(4, 12);
      else if (img <= 240) n = img * $urandom_range(1, 2);
      else n = $urandom_range(40, 160);
      // a few broken images
      if ($urandom_range(0, 7) == 0) n = n + $urandom_range(1, 5);
      if (phase_no == 3) begin
        n = 120;
        want_long_hold <= 1'b1;
      end

      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 11) == 0)
          queue_pal(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        queue_data(8'($urandom));
      end
      settle();
      phase_no++;
    end

    settle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("bmp_pixel_to_rgb555_top_tb: done, clean");
    end else begin
      $display("bmp_pixel_to_rgb555_top_tb: done, errors");
    end
    $finish;
  end

endmodule
